### sv/control_channel_search_space_ecce_macros.svh
// assertion macros for the control channel search space ecce block
// used by the top level only, no other dependencies
`ifndef CONTROL_CHANNEL_SEARCH_SPACE_ECCE_MACROS_SVH
`define CONTROL_CHANNEL_SEARCH_SPACE_ECCE_MACROS_SVH

// same-cycle implication
`define CCSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ccss assertion failed");

// next-cycle implication
`define CCSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ccss assertion failed");

`endif

### sv/ccss_pkg.sv
// shared types and constants of the ecce search space block
// no dependencies
package ccss_pkg;

  localparam int unsigned MAX_ECCE       = 32;
  localparam int unsigned MAX_CANDIDATES = 8;
  localparam int unsigned MAX_LEVEL      = 32;

  localparam int unsigned NW        = 6;
  localparam int unsigned DVW       = 17;
  localparam int unsigned DSW       = 10;
  localparam int unsigned DIV_CNT_W = $clog2(DVW + 1);
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [15:0] HASH_A = 16'd39827;
  localparam logic [16:0] HASH_D = 17'd65537;

  localparam logic [CFG_IDX_W-1:0] CFG_RNTI        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRB_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EIGHT_EREGS = 2'd2;

  localparam logic [3:0] PRB_COUNT_RST = 4'd2;

  typedef struct packed {
    logic [3:0] subframe;
    logic [5:0] level;
    logic [2:0] candidate;
    logic [3:0] candidate_count;
  } in_word_t;

  typedef struct packed {
    logic [4:0] ecce_index;
    logic       last;
    logic       error;
  } out_word_t;

  typedef enum logic [1:0] {
    DIV_GROUPS,
    DIV_OFFSET,
    DIV_MOD
  } div_sel_e;

  typedef struct packed {
    logic     cap_in;
    logic     hash_start;
    logic     div_start;
    div_sel_e div_sel;
    logic     store_grp;
    logic     store_off;
    logic     store_mod;
    logic     calc_start;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_err;
    logic hash_busy;
    logic div_busy;
    logic last_word;
  } dp_stat_t;

endpackage

### sv/ccss_div.sv
// restoring divider, one quotient bit per cycle
// depends on ccss_pkg
module ccss_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [ccss_pkg::DVW-1:0] dividend_i,
  input  logic [ccss_pkg::DSW-1:0] divisor_i,
  output logic                     busy_o,
  output logic [ccss_pkg::DVW-1:0] quot_o,
  output logic [ccss_pkg::DSW-1:0] rem_o
);
  import ccss_pkg::*;

  logic                 busy_q, busy_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DVW-1:0]       quot_q;
  logic [DSW-1:0]       rem_q;
  logic [DSW-1:0]       dsr_q;
  logic [DSW:0]         shifted;
  logic [DSW:0]         reduced;
  logic                 ge;

  assign shifted = {rem_q, quot_q[DVW-1]};
  assign ge      = shifted >= {1'b0, dsr_q};
  assign reduced = shifted - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DVW);
    end else if (busy_q) begin
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[DVW-2:0], ge};
      rem_q  <= ge ? reduced[DSW-1:0] : shifted[DSW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

### sv/ccss_datapath.sv
// datapath: config registers, hash recursion, shared divider, word assembly
// depends on ccss_pkg and ccss_div
module ccss_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ccss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ccss_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  ccss_pkg::in_word_t             in_i,
  input  ccss_pkg::ctrl_cmd_t            cmd_i,
  output ccss_pkg::dp_stat_t             stat_o,
  output ccss_pkg::out_word_t            out_o
);
  import ccss_pkg::*;

  logic [15:0]   rnti_q;
  logic [3:0]    prb_q;
  logic          eight_q;

  logic [NW-1:0] ecce_raw;
  logic [NW-1:0] ecce_n;
  logic          in_err;

  logic [5:0]    lvl_q;
  logic [2:0]    m_q;
  logic [3:0]    cnt_q;
  logic          err_q;

  logic          hash_busy_q;
  logic          hash_mul_q;
  logic [4:0]    rnd_q;
  logic [16:0]   y_q;
  logic [31:0]   prod_q;
  logic [32:0]   mul_full;
  logic [17:0]   red_diff;
  logic [16:0]   y_red;

  logic [8:0]     mn;
  logic [9:0]     lc;
  logic [DVW-1:0] div_dividend;
  logic [DSW-1:0] div_divisor;
  logic           div_busy;
  logic [DVW-1:0] div_quot;
  logic [DSW-1:0] div_rem;

  logic [NW-1:0]   grp_q;
  logic [NW-1:0]   off_q;
  logic [NW-1:0]   mod_q;
  logic [NW-1:0]   start_q;
  logic [NW-1:0]   idx_q;
  logic [2*NW-1:0] scaled;
  logic [NW-1:0]   pos;
  logic            last_word;
  out_word_t       out_q;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnti_q  <= '0;
      prb_q   <= PRB_COUNT_RST;
      eight_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RNTI:        rnti_q  <= cfg_data_i;
        CFG_PRB_COUNT:   prb_q   <= cfg_data_i[3:0];
        CFG_EIGHT_EREGS: eight_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ecce count and request check
  assign ecce_raw = eight_q ? {1'b0, prb_q, 1'b0} : {prb_q, 2'b00};
  assign ecce_n   = (ecce_raw > NW'(MAX_ECCE)) ? NW'(MAX_ECCE) : ecce_raw;

  assign in_err = (in_i.candidate_count == 4'd0) ||
                  ({1'b0, in_i.candidate} >= in_i.candidate_count) ||
                  ({1'b0, in_i.candidate_count} > 5'(MAX_CANDIDATES)) ||
                  (in_i.level == 6'd0) ||
                  (in_i.level > ecce_n) ||
                  ({1'b0, in_i.level} > 7'(MAX_LEVEL));

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      lvl_q <= in_i.level;
      m_q   <= in_i.candidate;
      cnt_q <= in_i.candidate_count;
      err_q <= in_err;
    end
  end

  // hash recursion, multiply then fold mod 2^16+1
  assign mul_full = 33'(HASH_A) * 33'(y_q);
  assign red_diff = {2'b00, prod_q[15:0]} - {2'b00, prod_q[31:16]};
  assign y_red    = red_diff[17] ? 17'(red_diff + 18'(HASH_D)) : red_diff[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_busy_q <= 1'b0;
      hash_mul_q  <= 1'b0;
    end else if (cmd_i.hash_start) begin
      hash_busy_q <= 1'b1;
      hash_mul_q  <= 1'b1;
    end else if (hash_busy_q) begin
      hash_mul_q <= !hash_mul_q;
      if (!hash_mul_q && rnd_q == 5'd1) begin
        hash_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hash_start) begin
      y_q   <= {1'b0, rnti_q};
      rnd_q <= {1'b0, in_i.subframe} + 5'd1;
    end else if (hash_busy_q) begin
      if (hash_mul_q) begin
        prod_q <= mul_full[31:0];
      end else begin
        y_q   <= y_red;
        rnd_q <= rnd_q - 5'd1;
      end
    end
  end

  // divider operands
  assign mn = 9'(m_q) * 9'(ecce_n);
  assign lc = 10'(lvl_q) * 10'(cnt_q);

  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_GROUPS: begin
        div_dividend = DVW'(ecce_n);
        div_divisor  = DSW'(lvl_q);
      end
      DIV_OFFSET: begin
        div_dividend = DVW'(mn);
        div_divisor  = DSW'(lc);
      end
      DIV_MOD: begin
        div_dividend = y_q + DVW'(off_q);
        div_divisor  = DSW'(grp_q);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  ccss_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // start position and word assembly
  assign scaled    = (2*NW)'(lvl_q) * (2*NW)'(mod_q);
  assign pos       = start_q + idx_q;
  assign last_word = err_q || (idx_q == lvl_q - 6'd1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_grp) begin
      grp_q <= div_quot[NW-1:0];
    end
    if (cmd_i.store_off) begin
      off_q <= div_quot[NW-1:0];
    end
    if (cmd_i.store_mod) begin
      mod_q <= div_rem[NW-1:0];
    end
    if (cmd_i.calc_start) begin
      start_q <= scaled[NW-1:0];
      idx_q   <= '0;
    end else if (cmd_i.load_out) begin
      idx_q <= idx_q + NW'(1);
    end
    if (cmd_i.load_out) begin
      out_q.ecce_index <= err_q ? 5'd0 : pos[4:0];
      out_q.last       <= last_word;
      out_q.error      <= err_q;
    end
  end

  assign stat_o.in_err    = in_err;
  assign stat_o.hash_busy = hash_busy_q;
  assign stat_o.div_busy  = div_busy;
  assign stat_o.last_word = last_word;
  assign out_o            = out_q;

endmodule

### sv/ccss_ctrl.sv
// controller state machine: sequences hash, divisions and word output
// depends on ccss_pkg
module ccss_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ccss_pkg::dp_stat_t  stat_i,
  output ccss_pkg::ctrl_cmd_t cmd_o
);
  import ccss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_GRP,
    S_OFF,
    S_HASH,
    S_MOD,
    S_SCALE,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load;

  assign load = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    cmd_o         = '0;
    cmd_o.div_sel = DIV_GROUPS;
    state_d       = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          if (stat_i.in_err) begin
            state_d = S_EMIT;
          end else begin
            cmd_o.hash_start = 1'b1;
            state_d          = S_START;
          end
        end
      end
      S_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_GROUPS;
        state_d         = S_GRP;
      end
      S_GRP: begin
        if (!stat_i.div_busy) begin
          cmd_o.store_grp = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_OFFSET;
          state_d         = S_OFF;
        end
      end
      S_OFF: begin
        if (!stat_i.div_busy) begin
          cmd_o.store_off = 1'b1;
          state_d         = S_HASH;
        end
      end
      S_HASH: begin
        if (!stat_i.hash_busy) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_MOD;
          state_d         = S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.div_sel = DIV_MOD;
        if (!stat_i.div_busy) begin
          cmd_o.store_mod = 1'b1;
          state_d         = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd_o.calc_start = 1'b1;
        state_d          = S_EMIT;
      end
      S_EMIT: begin
        cmd_o.load_out = load;
        if (load && stat_i.last_word) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

### sv/control_channel_search_space_ecce.sv
// top level of the ecce search space block: controller, datapath, assertions
// depends on ccss_pkg, ccss_ctrl, ccss_datapath and the assertion macro header
//
// usage
// - config channel (cfg_valid_i/cfg_index_i/cfg_data_i) is always ready; index 0 rnti,
//   1 prb count, 2 eight eregs per ecce; write only while the block is idle
// - input channel takes one request word (subframe, level, candidate, count) while idle
// - output channel gives level words of ecce indices, last set on the final one;
//   a rejected request gives a single word with error and last set
// - sequence: a rejected request goes from idle straight to the emit state, where its
//   word is loaded once the output register is free; otherwise the shared divider runs
//   for groups, then offset, then the modulo once the hash recursion (which runs alongside
//   the first two) is done; the start position is then scaled and words follow at one per
//   cycle while the receiver is ready; one request is handled at a time
// - a stalled receiver holds the output register and the word stream pauses; the next
//   request is taken once the final word sits in the output register
// - reset clears the config registers to rnti 0, prb count 2, four eregs per ecce, and
//   returns the controller to idle with no word pending
`include "control_channel_search_space_ecce_macros.svh"

module control_channel_search_space_ecce (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ccss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ccss_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ccss_pkg::in_word_t             in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ccss_pkg::out_word_t            out_o
);
  import ccss_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  ccss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ccss_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_o       (out_o)
  );

  `CCSS_ASSERT_IMP(a_err_word, clk_i, rst_ni, out_valid_o && out_o.error,
                   out_o.last && (out_o.ecce_index == 5'd0))
  `CCSS_ASSERT_IMP(a_idle_units, clk_i, rst_ni, in_ready_o,
                   !stat.div_busy && !stat.hash_busy)
  `CCSS_ASSERT_IMP(a_div_free, clk_i, rst_ni, cmd.div_start, !stat.div_busy)
  `CCSS_ASSERT_NXT(a_leave_idle, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

endmodule
